>>> hdl/exl_pkg.sv
`timescale 1ns / 1ps

package exl_pkg;

    // Widths of the stream payloads.
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned USER_W = KIND_W + 4;

    // Character codes that the lexer looks for.
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;

    // Token kinds as reported in the output beat.
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_SYMBOL = 3'd2,
        KIND_SUM    = 3'd3,
        KIND_MUL    = 3'd4,
        KIND_LPAR   = 3'd5,
        KIND_RPAR   = 3'd6
    } t_kind;

    // Scanner state, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NUMBER = 4'b0010,
        MODE_SYMBOL = 4'b0100,
        MODE_ERROR  = 4'b1000
    } t_mode;

    // Character classes decoded from one code.
    typedef struct packed {
        logic is_space;
        logic is_digit;
        logic is_dot;
        logic is_word;   // letter or underscore
        logic is_sum;
        logic is_mul;
        logic is_lpar;
        logic is_rpar;
        logic is_delim;
    } t_char_class;

    // Result flags of one character.
    typedef struct packed {
        logic  line_error;
        logic  ends_here;
        logic  ends_previous;
        logic  starts_token;
        t_kind token_kind;
    } t_result;

endpackage

>>> hdl/exl_class.sv
`timescale 1ns / 1ps

module exl_class (
    input  logic [exl_pkg::CHAR_W-1:0] i_char,
    output exl_pkg::t_char_class       o_class
);

    logic w_space;
    logic w_rpar;
    logic w_sum;
    logic w_mul;

    // Whitespace is tab through carriage return, and the space itself.
    assign w_space = (i_char == exl_pkg::CH_SPACE)
                   || (i_char >= exl_pkg::CH_TAB && i_char <= exl_pkg::CH_CR);
    assign w_rpar  = (i_char == exl_pkg::CH_RPAR);
    assign w_sum   = (i_char == exl_pkg::CH_PLUS) || (i_char == exl_pkg::CH_MINUS);
    assign w_mul   = (i_char == exl_pkg::CH_STAR) || (i_char == exl_pkg::CH_SLASH);

    // Decode every class in parallel.
    always_comb begin
        o_class.is_space = w_space;
        o_class.is_digit = (i_char >= exl_pkg::CH_ZERO) && (i_char <= exl_pkg::CH_NINE);
        o_class.is_dot   = (i_char == exl_pkg::CH_DOT);
        o_class.is_word  = ((i_char >= exl_pkg::CH_LOW_A) && (i_char <= exl_pkg::CH_LOW_Z))
                         || ((i_char >= exl_pkg::CH_UP_A) && (i_char <= exl_pkg::CH_UP_Z))
                         || (i_char == exl_pkg::CH_UNDER);
        o_class.is_sum   = w_sum;
        o_class.is_mul   = w_mul;
        o_class.is_lpar  = (i_char == exl_pkg::CH_LPAR);
        o_class.is_rpar  = w_rpar;
        o_class.is_delim = w_space || w_rpar || w_sum || w_mul;
    end

endmodule

>>> hdl/exl_scan.sv
`timescale 1ns / 1ps

module exl_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  exl_pkg::t_char_class i_class,
    input  logic                 i_last,
    output exl_pkg::t_result     o_result,
    output logic                 o_idle
);

    exl_pkg::t_mode r_mode;
    exl_pkg::t_mode n_mode;
    logic           r_dot;
    logic           n_dot;

    // Step logic: first finish any token in progress, then look at the
    // character from the between-tokens view if the token has ended.
    always_comb begin
        exl_pkg::t_mode  v_mode;
        exl_pkg::t_result v_res;
        logic            v_dot;
        logic            v_err;

        v_mode = r_mode;
        v_dot  = r_dot;
        v_err  = 1'b0;
        v_res  = '{line_error: 1'b0, ends_here: 1'b0, ends_previous: 1'b0,
                   starts_token: 1'b0, token_kind: exl_pkg::KIND_NONE};

        unique case (r_mode)
            exl_pkg::MODE_ERROR: begin
                v_err = 1'b1;
            end
            exl_pkg::MODE_NUMBER: begin
                if (i_class.is_digit) begin
                    v_res.token_kind = exl_pkg::KIND_NUMBER;
                end else if (i_class.is_dot) begin
                    if (r_dot) begin
                        v_err = 1'b1;
                    end else begin
                        v_dot            = 1'b1;
                        v_res.token_kind = exl_pkg::KIND_NUMBER;
                    end
                end else if (i_class.is_delim) begin
                    v_res.ends_previous = 1'b1;
                    v_mode              = exl_pkg::MODE_IDLE;
                end else begin
                    v_err = 1'b1;
                end
            end
            exl_pkg::MODE_SYMBOL: begin
                if (i_class.is_word || i_class.is_digit) begin
                    v_res.token_kind = exl_pkg::KIND_SYMBOL;
                end else if (i_class.is_delim) begin
                    v_res.ends_previous = 1'b1;
                    v_mode              = exl_pkg::MODE_IDLE;
                end else begin
                    v_err = 1'b1;
                end
            end
            default: begin
                v_mode = exl_pkg::MODE_IDLE;
            end
        endcase

        // Between tokens: start a new token or skip whitespace.
        if (!v_err && v_mode == exl_pkg::MODE_IDLE) begin
            priority if (i_class.is_space) begin
                v_res.token_kind = exl_pkg::KIND_NONE;
            end else if (i_class.is_digit || i_class.is_dot) begin
                v_res.token_kind   = exl_pkg::KIND_NUMBER;
                v_res.starts_token = 1'b1;
                v_dot              = i_class.is_dot;
                v_mode             = exl_pkg::MODE_NUMBER;
            end else if (i_class.is_sum) begin
                v_res.token_kind   = exl_pkg::KIND_SUM;
                v_res.starts_token = 1'b1;
                v_res.ends_here    = 1'b1;
            end else if (i_class.is_mul) begin
                v_res.token_kind   = exl_pkg::KIND_MUL;
                v_res.starts_token = 1'b1;
                v_res.ends_here    = 1'b1;
            end else if (i_class.is_lpar) begin
                v_res.token_kind   = exl_pkg::KIND_LPAR;
                v_res.starts_token = 1'b1;
                v_res.ends_here    = 1'b1;
            end else if (i_class.is_rpar) begin
                v_res.token_kind   = exl_pkg::KIND_RPAR;
                v_res.starts_token = 1'b1;
                v_res.ends_here    = 1'b1;
            end else if (i_class.is_word) begin
                v_res.token_kind   = exl_pkg::KIND_SYMBOL;
                v_res.starts_token = 1'b1;
                v_mode             = exl_pkg::MODE_SYMBOL;
            end else begin
                v_err = 1'b1;
            end
        end

        // An error blanks the flags; the end of line closes an open token.
        if (v_err) begin
            v_res  = '{line_error: 1'b1, ends_here: 1'b0, ends_previous: 1'b0,
                       starts_token: 1'b0, token_kind: exl_pkg::KIND_NONE};
            v_mode = exl_pkg::MODE_ERROR;
        end else if (i_last && (v_mode == exl_pkg::MODE_NUMBER
                                || v_mode == exl_pkg::MODE_SYMBOL)) begin
            v_res.ends_here = 1'b1;
        end

        o_result = v_res;

        // A new line always starts clean.
        if (i_last) begin
            n_mode = exl_pkg::MODE_IDLE;
            n_dot  = 1'b0;
        end else begin
            n_mode = v_mode;
            n_dot  = (v_mode == exl_pkg::MODE_NUMBER) ? v_dot : 1'b0;
        end
    end

    // State advances once per character handed to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= exl_pkg::MODE_IDLE;
            r_dot  <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
        end
    end

    assign o_idle = (r_mode == exl_pkg::MODE_IDLE) && !r_dot;

endmodule

>>> hdl/expression_lexer.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata                 tuser                                    tlast
// s_axis   in         [7:0] char_code       -                                        last_in_line
// m_axis   out        [7:0] char_echo       [2:0] kind, [3] start, [4] ends_prev,    line_done
//                                           [5] ends_here, [6] line_error
//
// One character per cycle sustained while the output is not stalled; each beat
// passes from input to output through the input register, then the result register.
// The scanner state advances as a character moves into the result register.
// Synchronous active-low reset returns the scanner to between-token state.
// A stalled output holds its beat; the input register keeps taking a beat
// whenever the result register is free or drains in the same cycle.

module expression_lexer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [exl_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [exl_pkg::CHAR_W-1:0]  m_axis_tdata,   // [7:0] char_echo
    output logic [exl_pkg::USER_W-1:0]  m_axis_tuser,   // [2:0] token_kind, [3] starts_token,
                                                        // [4] ends_previous, [5] ends_here,
                                                        // [6] line_error
    output logic                        m_axis_tlast
);

    logic                       r_in_valid;
    logic [exl_pkg::CHAR_W-1:0] r_in_char;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic [exl_pkg::CHAR_W-1:0] r_out_char;
    exl_pkg::t_result           r_out_res;
    logic                       r_out_last;

    logic                       w_out_free;
    logic                       w_adv;
    exl_pkg::t_char_class       w_class;
    exl_pkg::t_result           w_res;
    logic                       w_idle;

    // Stage handshake: the result register frees when empty or drained.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    exl_class u_class (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    exl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_class  (w_class),
        .i_last   (r_in_last),
        .o_result (w_res),
        .o_idle   (w_idle)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_char <= r_in_char;
            r_out_res  <= w_res;
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_res;
    assign m_axis_tlast  = r_out_last;

    // An errored character carries no token flags.
    a_error_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.line_error) |->
            (r_out_res.token_kind == exl_pkg::KIND_NONE && !r_out_res.starts_token
             && !r_out_res.ends_previous && !r_out_res.ends_here))
        else $error("line_error beat carries token flags");

    // A token start always names a real token kind.
    a_start_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.starts_token) |->
            (r_out_res.token_kind != exl_pkg::KIND_NONE))
        else $error("token start without a kind");

    // The last character of a line leaves the scanner clean.
    a_line_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> w_idle)
        else $error("scanner not idle after end of line");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // Bench timing and run shape.
    localparam int unsigned DIR_N      = 27;
    localparam int unsigned PHASE_N    = 3;
    localparam int unsigned PHASE_BEATS = 575;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_MAX  = 10;

    typedef logic [exl_pkg::CHAR_W-1:0] t_char;

    // One row of the directed stimulus; a flagged row expects an error beat.
    typedef struct packed {
        t_char ch;
        logic  last;
        logic  want_err;
    } t_dir_row;

    // One lexed character as it leaves the block.
    typedef struct packed {
        t_char          ch;
        exl_pkg::t_kind kind;
        logic           starts;
        logic           ends_prev;
        logic           ends_here;
        logic           err;
        logic           done;
    } t_lex_beat;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    t_char                       s_tdata = '0;
    logic                        s_tlast = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    t_char                       m_tdata;
    logic [exl_pkg::USER_W-1:0]  m_tuser;
    logic                        m_tlast;

    // Scanner state of the predictor.
    exl_pkg::t_mode      scan_st = exl_pkg::MODE_IDLE;
    logic                dot_flag = 1'b0;

    t_lex_beat           lexed_q[$];
    t_char               line_q[$];
    t_dir_row            dir_tab [DIR_N];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         hold_left = 0;
    int unsigned         fail_cnt = 0;
    int unsigned         mismatch_cnt = 0;
    int unsigned         beats_in = 0;
    int unsigned         beats_out = 0;
    int unsigned         lines_sent = 0;
    int unsigned         tokens_seen = 0;
    int unsigned         err_beats = 0;
    int unsigned         quiet_cycles = 0;

    expression_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Character classes.
    function automatic logic is_space(input t_char c);
        return c == exl_pkg::CH_SPACE || (c >= exl_pkg::CH_TAB && c <= exl_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(input t_char c);
        return c >= exl_pkg::CH_ZERO && c <= exl_pkg::CH_NINE;
    endfunction

    function automatic logic is_word(input t_char c);
        return (c >= exl_pkg::CH_LOW_A && c <= exl_pkg::CH_LOW_Z) ||
               (c >= exl_pkg::CH_UP_A && c <= exl_pkg::CH_UP_Z) ||
               c == exl_pkg::CH_UNDER;
    endfunction

    function automatic logic is_delim(input t_char c);
        return is_space(c) || c == exl_pkg::CH_RPAR || c == exl_pkg::CH_PLUS ||
               c == exl_pkg::CH_MINUS || c == exl_pkg::CH_STAR || c == exl_pkg::CH_SLASH;
    endfunction

    // Appends one character to the line being built.
    function automatic void add_char(input t_char c);
        line_q = {line_q, c};
    endfunction

    // Lexes one character against the scanner state and advances that state.
    function automatic t_lex_beat lex_char(input t_char c, input logic last);
        t_lex_beat      r;
        exl_pkg::t_mode m;
        logic           err;
        r.ch = c;
        r.kind = exl_pkg::KIND_NONE;
        r.starts = 1'b0;
        r.ends_prev = 1'b0;
        r.ends_here = 1'b0;
        r.done = last;
        m = scan_st;
        err = 1'b0;

        // Continue or close the token in progress.
        case (m)
            exl_pkg::MODE_ERROR: begin
                err = 1'b1;
            end
            exl_pkg::MODE_NUMBER: begin
                if (is_digit(c)) begin
                    r.kind = exl_pkg::KIND_NUMBER;
                end else if (c == exl_pkg::CH_DOT) begin
                    if (dot_flag) begin
                        err = 1'b1;
                    end else begin
                        dot_flag = 1'b1;
                        r.kind = exl_pkg::KIND_NUMBER;
                    end
                end else if (is_delim(c)) begin
                    r.ends_prev = 1'b1;
                    m = exl_pkg::MODE_IDLE;
                end else begin
                    err = 1'b1;
                end
            end
            exl_pkg::MODE_SYMBOL: begin
                if (is_word(c) || is_digit(c)) begin
                    r.kind = exl_pkg::KIND_SYMBOL;
                end else if (is_delim(c)) begin
                    r.ends_prev = 1'b1;
                    m = exl_pkg::MODE_IDLE;
                end else begin
                    err = 1'b1;
                end
            end
            default: ;
        endcase

        // Between tokens: classify a fresh character.
        if (!err && m == exl_pkg::MODE_IDLE) begin
            if (is_space(c)) begin
                r.kind = exl_pkg::KIND_NONE;
            end else if (is_digit(c) || c == exl_pkg::CH_DOT) begin
                r.kind = exl_pkg::KIND_NUMBER;
                r.starts = 1'b1;
                dot_flag = (c == exl_pkg::CH_DOT);
                m = exl_pkg::MODE_NUMBER;
            end else if (c == exl_pkg::CH_PLUS || c == exl_pkg::CH_MINUS) begin
                r.kind = exl_pkg::KIND_SUM;
                r.starts = 1'b1;
                r.ends_here = 1'b1;
            end else if (c == exl_pkg::CH_STAR || c == exl_pkg::CH_SLASH) begin
                r.kind = exl_pkg::KIND_MUL;
                r.starts = 1'b1;
                r.ends_here = 1'b1;
            end else if (c == exl_pkg::CH_LPAR) begin
                r.kind = exl_pkg::KIND_LPAR;
                r.starts = 1'b1;
                r.ends_here = 1'b1;
            end else if (c == exl_pkg::CH_RPAR) begin
                r.kind = exl_pkg::KIND_RPAR;
                r.starts = 1'b1;
                r.ends_here = 1'b1;
            end else if (is_word(c)) begin
                r.kind = exl_pkg::KIND_SYMBOL;
                r.starts = 1'b1;
                m = exl_pkg::MODE_SYMBOL;
            end else begin
                err = 1'b1;
            end
        end

        // An error wipes every token flag; the end of the line closes a token.
        if (err) begin
            r.kind = exl_pkg::KIND_NONE;
            r.starts = 1'b0;
            r.ends_prev = 1'b0;
            r.ends_here = 1'b0;
            m = exl_pkg::MODE_ERROR;
        end else if (last && (m == exl_pkg::MODE_NUMBER || m == exl_pkg::MODE_SYMBOL)) begin
            r.ends_here = 1'b1;
        end
        r.err = err;

        if (last) begin
            scan_st = exl_pkg::MODE_IDLE;
            dot_flag = 1'b0;
        end else begin
            scan_st = m;
            if (m != exl_pkg::MODE_NUMBER) dot_flag = 1'b0;
        end
        return r;
    endfunction

    // Random character pickers for well-formed lines.
    function automatic t_char rand_space();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? exl_pkg::CH_SPACE : t_char'(exl_pkg::CH_TAB + k);
    endfunction

    function automatic t_char rand_word_char(input logic first);
        int unsigned k;
        k = $urandom_range(first ? 52 : 62);
        if (k < 26) return t_char'(exl_pkg::CH_LOW_A + k);
        if (k < 52) return t_char'(exl_pkg::CH_UP_A + k - 26);
        if (k == 52) return exl_pkg::CH_UNDER;
        return t_char'(exl_pkg::CH_ZERO + k - 53);
    endfunction

    // Builds one line: mostly well-formed expressions, some corrupted, some noise.
    task automatic build_line();
        int unsigned shape;
        int unsigned n_tok;
        int unsigned tok;
        int unsigned len;
        int unsigned dot_pos;
        logic        prev_word;
        line_q.delete();
        shape = $urandom_range(99);
        if (shape < 15) begin
            len = $urandom_range(10, 1);
            repeat (len) add_char(t_char'($urandom_range(255)));
        end else begin
            prev_word = 1'b0;
            n_tok = $urandom_range(8, 1);
            repeat (n_tok) begin
                tok = $urandom_range(5);
                // A number or symbol must be closed before another word or '('.
                if ((prev_word && (tok <= 1 || tok == 4)) || $urandom_range(3) == 0)
                    add_char(rand_space());
                case (tok)
                    0: begin
                        len = $urandom_range(5, 1);
                        dot_pos = $urandom_range(2 * len);
                        for (int i = 0; i < len; i++)
                            add_char((i == dot_pos) ? exl_pkg::CH_DOT :
                                     t_char'(exl_pkg::CH_ZERO + $urandom_range(9)));
                        if ($urandom_range(19) == 0) add_char(exl_pkg::CH_DOT);
                    end
                    1: begin
                        len = $urandom_range(5);
                        add_char(rand_word_char(1'b1));
                        repeat (len) add_char(rand_word_char(1'b0));
                    end
                    2: add_char($urandom_range(1) ? exl_pkg::CH_PLUS : exl_pkg::CH_MINUS);
                    3: add_char($urandom_range(1) ? exl_pkg::CH_STAR : exl_pkg::CH_SLASH);
                    4: add_char(exl_pkg::CH_LPAR);
                    default: add_char(exl_pkg::CH_RPAR);
                endcase
                prev_word = (tok <= 1);
            end
            if ($urandom_range(3) == 0) add_char(rand_space());
            if (shape < 30)
                line_q[$urandom_range(line_q.size() - 1)] = t_char'($urandom_range(255));
        end
    endtask

    // Offers one character and records its expected beat once it is taken.
    task automatic offer_char(input t_char c, input logic last, input logic want_err);
        t_lex_beat b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        b = lex_char(c, last);
        if (want_err) begin
            b.kind = exl_pkg::KIND_NONE;
            b.starts = 1'b0;
            b.ends_prev = 1'b0;
            b.ends_here = 1'b0;
            b.err = 1'b1;
            b.done = last;
        end
        lexed_q = {lexed_q, b};
        beats_in++;
    endtask

    // Receiver: random back-pressure, with one long hold-off when asked.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge i_clk);
        end
    end

    // Output checker: every beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_lex_beat got;
        t_lex_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.ch = m_tdata;
            got.kind = exl_pkg::t_kind'(m_tuser[2:0]);
            got.starts = m_tuser[3];
            got.ends_prev = m_tuser[4];
            got.ends_here = m_tuser[5];
            got.err = m_tuser[6];
            got.done = m_tlast;
            beats_out++;
            if (got.starts) tokens_seen++;
            if (got.err) err_beats++;
            if (lexed_q.size() == 0) begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected output beat: ch=%02h", got.ch);
            end else begin
                want = lexed_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display({"mismatch at beat %0d: expected ch=%02h kind=%0d st=%b ",
                                  "ep=%b eh=%b err=%b done=%b, got ch=%02h kind=%0d st=%b ",
                                  "ep=%b eh=%b err=%b done=%b"},
                                 beats_out, want.ch, want.kind, want.starts,
                                 want.ends_prev, want.ends_here, want.err, want.done,
                                 got.ch, got.kind, got.starts, got.ends_prev,
                                 got.ends_here, got.err, got.done);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("stream stalled for %0d cycles", quiet_cycles);
            $display("[expression_lexer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial begin
        int unsigned phase_beats;
        logic        hold_done;
        hold_done = 1'b0;
        dir_tab = '{
            '{8'h00,             1'b1, 1'b1},   // lowest code is unknown
            '{8'hFF,             1'b1, 1'b1},   // highest code is unknown
            '{"1",               1'b0, 1'b0},
            '{"2",               1'b0, 1'b0},
            '{exl_pkg::CH_DOT,   1'b0, 1'b0},
            '{"5",               1'b0, 1'b0},
            '{exl_pkg::CH_PLUS,  1'b0, 1'b0},   // closes the number
            '{"x",               1'b0, 1'b0},
            '{exl_pkg::CH_UNDER, 1'b0, 1'b0},
            '{"9",               1'b0, 1'b0},
            '{exl_pkg::CH_STAR,  1'b0, 1'b0},
            '{exl_pkg::CH_LPAR,  1'b0, 1'b0},
            '{"Z",               1'b0, 1'b0},
            '{exl_pkg::CH_RPAR,  1'b0, 1'b0},
            '{exl_pkg::CH_SLASH, 1'b0, 1'b0},
            '{exl_pkg::CH_DOT,   1'b0, 1'b0},   // number opening with a dot
            '{"0",               1'b0, 1'b0},
            '{exl_pkg::CH_CR,    1'b0, 1'b0},
            '{exl_pkg::CH_MINUS, 1'b0, 1'b0},
            '{"a",               1'b1, 1'b0},   // symbol closed by end of line
            '{"7",               1'b0, 1'b0},
            '{exl_pkg::CH_DOT,   1'b0, 1'b0},
            '{exl_pkg::CH_DOT,   1'b0, 1'b1},   // second dot in a number
            '{"q",               1'b1, 1'b1},   // error stays until the line ends
            '{"a",               1'b0, 1'b0},
            '{exl_pkg::CH_LPAR,  1'b1, 1'b1},   // '(' straight after a symbol
            '{"9",               1'b1, 1'b0}    // number closed by end of line
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 50;
        foreach (dir_tab[i]) begin
            offer_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].want_err);
            if (dir_tab[i].last) lines_sent++;
        end

        for (int ph = 0; ph < PHASE_N; ph++) begin
            case (ph)
                0: begin send_idle_pct = 21; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                // Fill the block while the receiver holds off.
                if (ph == PHASE_N - 1 && phase_beats >= 100 && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                build_line();
                foreach (line_q[i])
                    offer_char(line_q[i], i == line_q.size() - 1, 1'b0);
                phase_beats += line_q.size();
                lines_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (lexed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("lexed %0d characters in %0d lines: %0d tokens started, %0d error beats",
                 beats_in, lines_sent, tokens_seen, err_beats);
        $display("idle mixes 21/50, 50/21 and none, with one long output hold-off; %0d failures",
                 fail_cnt);
        if (fail_cnt == 0 && lexed_q.size() == 0 && beats_out == beats_in) begin
            $display("[expression_lexer] OK");
        end else begin
            $display("[expression_lexer] ERROR");
        end
        $finish;
    end

endmodule
